>>> design/pmh_pkg.sv
package pmh_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int BIN_INDEX_W = 6;
   localparam int BIN_COUNT_W = 7;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_HIST_ENABLE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIST_MIN        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIST_MAX        = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIST_STEP       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIN_COUNT       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALERT_THRESHOLD = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPORT_INTERVAL = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ALERT,
      ST_CLASS,
      ST_DIV,
      ST_INC,
      ST_RDWAIT,
      ST_CLEAR,
      ST_OUT
   } pmh_state_type;

endpackage

>>> design/period_monitor_with_histogram.sv
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tuser: request type; tdata: timestamp, bin index
// rsp_      out        rsp_tvalid/rsp_tready  tdata: status, period, flags, bin, counters
// csr_      in         csr_we                 register index and write data, no read-back
//
// Requests are taken one at a time: req_tready is high only in ST_IDLE. A tick whose
// period lies between the histogram minimum and maximum waits on the serial divider, which
// retires one quotient bit a cycle; a clear walks the bin store one entry a cycle. After
// reset the same walk holds req_tready low until the last bin is cleared. A result waits in
// an output register while the next request is taken; a result that finds it still full
// holds until rsp_tready.
module period_monitor_with_histogram #(
   parameter int MAX_BINS    = 64,
   parameter int TIME_WIDTH  = 48,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   // timestamp_us, bin_index
   input  logic [((TIME_WIDTH + pmh_pkg::BIN_INDEX_W + 7) / 8) * 8 - 1:0] req_tdata,
   // req_type
   input  logic [pmh_pkg::REQ_TYPE_W-1:0]                         req_tuser,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // ok, period_us, alert, report, bin_value, below_count, beyond_count, total_count
   output logic [((3 + TIME_WIDTH + 4 * COUNT_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                                   csr_we,
   input  logic [pmh_pkg::CSR_ADDR_W-1:0]                         csr_addr,
   input  logic [TIME_WIDTH-1:0]                                  csr_wdata
);

   import pmh_pkg::*;

   localparam int ADDR_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int RSP_DATA_W = ((3 + TIME_WIDTH + 4 * COUNT_WIDTH + 7) / 8) * 8;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

   pmh_state_type state_ff, state_in;

   // configuration
   logic                   hist_en_ff;
   logic [TIME_WIDTH-1:0]  hist_min_ff;
   logic [TIME_WIDTH-1:0]  hist_max_ff;
   logic [TIME_WIDTH-1:0]  hist_step_ff;
   logic [BIN_COUNT_W-1:0] bin_count_ff;
   logic [TIME_WIDTH-1:0]  alert_thr_ff;
   logic [TIME_WIDTH-1:0]  rep_int_ff;

   // request in work
   logic [REQ_TYPE_W-1:0]  req_type_ff;
   logic [TIME_WIDTH-1:0]  ts_ff;
   logic [BIN_INDEX_W-1:0] bidx_ff;

   // monitor state
   logic [TIME_WIDTH-1:0]  last_time_ff;
   logic [TIME_WIDTH-1:0]  last_period_ff;
   logic [TIME_WIDTH-1:0]  last_rep_ff;
   logic [TIME_WIDTH-1:0]  rep_gap_ff;
   logic                   alert_ff;
   logic                   report_ff;
   logic [COUNT_WIDTH-1:0] below_ff;
   logic [COUNT_WIDTH-1:0] beyond_ff;
   logic [COUNT_WIDTH-1:0] total_ff;
   logic                   ok_ff;
   logic [COUNT_WIDTH-1:0] binv_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic                   clr_resp_ff;
   logic [ADDR_W-1:0]      bin_addr_ff;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_in;

   // shared datapath signals
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_addr;
   logic [COUNT_WIDTH-1:0] ram_wdata;
   logic [COUNT_WIDTH-1:0] ram_rdata;
   logic                   div_start;
   logic                   div_done;
   logic [TIME_WIDTH-1:0]  quotient;
   logic [TIME_WIDTH-1:0]  dividend;
   logic [TIME_WIDTH-1:0]  divisor;
   logic [BIN_COUNT_W-1:0] bins_used;
   logic                   tick_arm;
   logic                   tick_back;
   logic                   bidx_ok;
   logic                   quo_ok;
   logic                   out_free;
   logic                   clr_last;

   always_comb begin
      tick_arm  = (last_time_ff == '0);
      tick_back = (ts_ff < last_time_ff);
      bidx_ok   = (int'(bidx_ff) < MAX_BINS);
      bins_used = (int'(bin_count_ff) > MAX_BINS) ? BIN_COUNT_W'(MAX_BINS) : bin_count_ff;
      quo_ok    = (quotient < TIME_WIDTH'(bins_used));
      dividend  = last_period_ff - hist_min_ff;
      divisor   = (hist_step_ff == '0) ? TIME_WIDTH'(1) : hist_step_ff;
      out_free  = !rsp_valid_ff || rsp_tready;
      clr_last  = (clr_addr_ff == ADDR_W'(MAX_BINS - 1));
      rsp_data_in = RSP_DATA_W'({total_ff, beyond_ff, below_ff, binv_ff,
                                 report_ff, alert_ff, last_period_ff, ok_ff});
   end

   // sequencer: next state and bin store / divider controls
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_addr  = bin_addr_ff;
      ram_wdata = '0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (req_type_ff)
               REQ_TICK: begin
                  state_in = (tick_arm || tick_back) ? ST_OUT : ST_ALERT;
               end
               REQ_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               REQ_READ: begin
                  if (bidx_ok) begin
                     ram_addr = ADDR_W'(bidx_ff);
                     state_in = ST_RDWAIT;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_ALERT: begin
            state_in = hist_en_ff ? ST_CLASS : ST_OUT;
         end
         ST_CLASS: begin
            if (last_period_ff < hist_min_ff || last_period_ff >= hist_max_ff) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (quo_ok) begin
                  ram_addr = quotient[ADDR_W-1:0];
                  state_in = ST_INC;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_INC: begin
            ram_we    = 1'b1;
            ram_wdata = sat_inc(ram_rdata);
            state_in  = ST_OUT;
         end
         ST_RDWAIT: begin
            state_in = ST_OUT;
         end
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_addr_ff;
            if (clr_last) begin
               state_in = clr_resp_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_en_ff   <= 1'b0;
         hist_min_ff  <= '0;
         hist_max_ff  <= '0;
         hist_step_ff <= TIME_WIDTH'(1);
         bin_count_ff <= '0;
         alert_thr_ff <= '0;
         rep_int_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HIST_ENABLE:     hist_en_ff   <= csr_wdata[0];
            CSR_HIST_MIN:        hist_min_ff  <= csr_wdata;
            CSR_HIST_MAX:        hist_max_ff  <= csr_wdata;
            CSR_HIST_STEP:       hist_step_ff <= csr_wdata;
            CSR_BIN_COUNT:       bin_count_ff <= csr_wdata[BIN_COUNT_W-1:0];
            CSR_ALERT_THRESHOLD: alert_thr_ff <= csr_wdata;
            CSR_REPORT_INTERVAL: rep_int_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff   <= '0;
         last_period_ff <= '0;
         last_rep_ff    <= '0;
         alert_ff       <= 1'b0;
         report_ff      <= 1'b0;
         below_ff       <= '0;
         beyond_ff      <= '0;
         total_ff       <= '0;
         clr_addr_ff    <= '0;
         clr_resp_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  req_type_ff <= req_tuser;
                  ts_ff       <= req_tdata[TIME_WIDTH-1:0];
                  bidx_ff     <= req_tdata[TIME_WIDTH +: BIN_INDEX_W];
               end
            end
            ST_DECODE: begin
               ok_ff   <= 1'b1;
               binv_ff <= '0;
               case (req_type_ff)
                  REQ_TICK: begin
                     if (tick_arm) begin
                        last_time_ff   <= ts_ff;
                        last_period_ff <= '0;
                        last_rep_ff    <= ts_ff;
                     end else if (tick_back) begin
                        ok_ff <= 1'b0;
                     end else begin
                        last_time_ff   <= ts_ff;
                        last_period_ff <= ts_ff - last_time_ff;
                        rep_gap_ff     <= ts_ff - last_rep_ff;
                     end
                  end
                  REQ_CLEAR: begin
                     last_time_ff   <= '0;
                     last_period_ff <= '0;
                     last_rep_ff    <= '0;
                     alert_ff       <= 1'b0;
                     report_ff      <= 1'b0;
                     below_ff       <= '0;
                     beyond_ff      <= '0;
                     total_ff       <= '0;
                     clr_addr_ff    <= '0;
                     clr_resp_ff    <= 1'b1;
                  end
                  default: ;
               endcase
            end
            ST_ALERT: begin
               alert_ff  <= (last_period_ff >= alert_thr_ff);
               report_ff <= 1'b0;
               if (hist_en_ff && rep_gap_ff > rep_int_ff) begin
                  last_rep_ff <= ts_ff;
                  report_ff   <= (rep_int_ff != '0);
               end
            end
            ST_CLASS: begin
               if (last_period_ff < hist_min_ff) begin
                  below_ff <= sat_inc(below_ff);
                  total_ff <= sat_inc(total_ff);
               end else if (last_period_ff >= hist_max_ff) begin
                  beyond_ff <= sat_inc(beyond_ff);
                  total_ff  <= sat_inc(total_ff);
               end
            end
            ST_DIV: begin
               if (div_done && quo_ok) begin
                  bin_addr_ff <= quotient[ADDR_W-1:0];
               end
            end
            ST_INC: begin
               total_ff <= sat_inc(total_ff);
            end
            ST_RDWAIT: begin
               binv_ff <= ram_rdata;
            end
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            end
            default: ;
         endcase
      end
   end

   // output register: load when the previous beat has gone or goes now
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   pmh_div #(
      .WIDTH (TIME_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   pmh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/pmh_ram.sv
module pmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
   input  logic [WIDTH-1:0]                              wdata,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/pmh_div.sv
module pmh_div #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff;
   logic [CW-1:0]    count_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = trial[WIDTH] ? shifted[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_in  = {quo_ff[WIDTH-2:0], ~trial[WIDTH]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= '0;
            quo_ff   <= dividend;
            dvs_ff   <= divisor;
            count_ff <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            quo_ff   <= quo_in;
            count_ff <= count_ff + CW'(1);
            if (count_ff == CW'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
